// ===== sv/sha256_pkg.sv =====
`timescale 1ns / 1ps

package sha256_pkg;

    typedef logic [31:0] t_word;

    // one schedule word on its way from the front to the compression core
    typedef struct packed {
        t_word word;
        logic  final_blk;   // last word of the last block of a message
    } t_qword;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam t_word H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== sv/sha256_in_if.sv =====
`timescale 1ns / 1ps

interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, data_byte, byte_valid, last, input ready);
    modport sink   (input valid, data_byte, byte_valid, last, output ready);
endinterface

// ===== sv/sha256_out_if.sv =====
`timescale 1ns / 1ps

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_word_0;
    logic [31:0] hash_word_1;
    logic [31:0] hash_word_2;
    logic [31:0] hash_word_3;
    logic [31:0] hash_word_4;
    logic [31:0] hash_word_5;
    logic [31:0] hash_word_6;
    logic [31:0] hash_word_7;

    modport source (output valid, hash_word_0, hash_word_1, hash_word_2, hash_word_3,
                    hash_word_4, hash_word_5, hash_word_6, hash_word_7, input ready);
    modport sink   (input valid, hash_word_0, hash_word_1, hash_word_2, hash_word_3,
                    hash_word_4, hash_word_5, hash_word_6, hash_word_7, output ready);
endinterface

// ===== sv/sha256_front.sv =====
`timescale 1ns / 1ps

module sha256_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sha256_in_if.sink           i_in,
    input  logic                i_q_full,
    output logic                o_q_push,
    output sha256_pkg::t_qword  o_q_data
);

    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_MARK = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_LEN  = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bit_len, n_bit_len;
    logic [2:0]  r_len_idx, n_len_idx;
    logic [23:0] r_word;

    logic        w_acc;
    logic        w_step;
    logic [7:0]  w_byte;

    assign i_in.ready = (r_state == ST_DATA) && !i_q_full;
    assign w_acc      = i_in.valid && i_in.ready;

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_bit_len = r_bit_len;
        n_len_idx = r_len_idx;
        w_step    = 1'b0;
        w_byte    = i_in.data_byte;
        unique case (r_state)
            ST_DATA: begin
                if (w_acc) begin
                    w_step = i_in.byte_valid;
                    if (i_in.byte_valid) begin
                        n_bit_len = r_bit_len + 64'd8;
                    end
                    if (i_in.last) begin
                        n_state = ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                w_step = !i_q_full;
                w_byte = sha256_pkg::PAD_MARK;
                if (w_step) begin
                    n_state = (r_fill + 6'd1 == sha256_pkg::LEN_POS) ? ST_LEN : ST_ZERO;
                end
            end
            ST_ZERO: begin
                w_step = !i_q_full;
                w_byte = 8'h00;
                if (w_step && (r_fill + 6'd1 == sha256_pkg::LEN_POS)) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                w_step = !i_q_full;
                // big-endian: most significant length byte first
                w_byte = r_bit_len[{~r_len_idx, 3'b000} +: 8];
                if (w_step) begin
                    n_len_idx = r_len_idx + 3'd1;
                    if (r_len_idx == 3'd7) begin
                        n_state   = ST_DATA;
                        n_bit_len = 64'd0;
                    end
                end
            end
            default: n_state = ST_DATA;
        endcase
        if (w_step) begin
            n_fill = r_fill + 6'd1;
        end
    end

    assign o_q_push           = w_step && (r_fill[1:0] == 2'b11);
    assign o_q_data.word      = {r_word, w_byte};
    assign o_q_data.final_blk = (r_state == ST_LEN) && (r_len_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_DATA;
            r_fill    <= 6'd0;
            r_bit_len <= 64'd0;
            r_len_idx <= 3'd0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_bit_len <= n_bit_len;
            r_len_idx <= n_len_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_word <= {r_word[15:0], w_byte};
        end
    end

    a_final_ends_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_push && o_q_data.final_blk) |-> (r_fill == 6'd63))
        else $error("final word not at end of block");

    a_len_in_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LEN) |-> (r_fill[5:3] == 3'b111))
        else $error("length bytes outside block tail");

endmodule

// ===== sv/sha256_fifo.sv =====
`timescale 1ns / 1ps

module sha256_fifo #(
    parameter int P_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sha256_pkg::t_qword  i_data,
    output logic                o_full,
    input  logic                i_pop,
    output sha256_pkg::t_qword  o_data,
    output logic                o_empty
);

    localparam int PTR_W = $clog2(P_DEPTH);
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    sha256_pkg::t_qword r_mem [P_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(P_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue overflow");

endmodule

// ===== sv/sha256_core.sv =====
`timescale 1ns / 1ps

module sha256_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    input  sha256_pkg::t_qword  i_q_data,
    sha256_out_if.source        o_out
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;

    logic [1:0]        r_state;
    logic [3:0]        r_wcnt;
    logic [5:0]        r_round;
    logic              r_final;
    logic              r_out_valid;
    sha256_pkg::t_word r_w   [16];
    sha256_pkg::t_word r_v   [8];
    sha256_pkg::t_word r_h   [8];
    sha256_pkg::t_word r_dig [8];

    sha256_pkg::t_word w_t1, w_t2, w_ch, w_maj, w_new;
    logic              w_add_go;

    assign o_q_pop = (r_state == ST_LOAD) && !i_q_empty;

    assign w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t1  = r_v[7] + sha256_pkg::big_sigma1(r_v[4]) + w_ch
                 + sha256_pkg::K_ROUND[r_round] + r_w[0];
    assign w_t2  = sha256_pkg::big_sigma0(r_v[0]) + w_maj;
    assign w_new = r_w[0] + sha256_pkg::small_sigma0(r_w[1]) + r_w[9]
                 + sha256_pkg::small_sigma1(r_w[14]);

    // hold the last block's result while the previous digest is still unread
    assign w_add_go = !(r_final && r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_wcnt      <= 4'd0;
            r_round     <= 6'd0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha256_pkg::H_INIT[i];
            end
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (o_q_pop) begin
                        r_wcnt <= r_wcnt + 4'd1;
                        if (r_wcnt == 4'd15) begin
                            r_state <= ST_ROUND;
                            r_final <= i_q_data.final_blk;
                            r_round <= 6'd0;
                        end
                    end
                end
                ST_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    if (w_add_go) begin
                        r_state <= ST_LOAD;
                        for (int i = 0; i < 8; i++) begin
                            r_h[i] <= r_final ? sha256_pkg::H_INIT[i] : r_h[i] + r_v[i];
                        end
                        if (r_final) begin
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= i_q_data.word;
        end else if (r_state == ST_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
        end
        if (r_state == ST_LOAD) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (r_state == ST_ROUND) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
        if ((r_state == ST_ADD) && w_add_go && r_final) begin
            for (int i = 0; i < 8; i++) begin
                r_dig[i] <= r_h[i] + r_v[i];
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.hash_word_0 = r_dig[0];
    assign o_out.hash_word_1 = r_dig[1];
    assign o_out.hash_word_2 = r_dig[2];
    assign o_out.hash_word_3 = r_dig[3];
    assign o_out.hash_word_4 = r_dig[4];
    assign o_out.hash_word_5 = r_dig[5];
    assign o_out.hash_word_6 = r_dig[6];
    assign o_out.hash_word_7 = r_dig[7];

    a_digest_from_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_ADD))
        else $error("digest raised outside final add");

    a_final_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_data.final_blk) |-> (r_wcnt == 4'd15))
        else $error("final word not last of block");

    a_rounds_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_wcnt == 4'd0))
        else $error("rounds started on partial block");

endmodule

// ===== sv/sha256_message_hasher_top.sv =====
`timescale 1ns / 1ps

// SHA-256 hasher fed one message byte per word on i_in.
// i_in carries data_byte, byte_valid and last; a word with last set closes
// the message (byte_valid 0 with last 1 closes it without adding a byte).
// o_out carries one word per message: the eight digest words hash_word_0..7.
// The front takes one input word per cycle while the word queue has room and
// packs bytes into 32-bit schedule words. On last it stops taking input and
// emits padding and length at one byte per cycle while the queue has room
// (9 to 72 bytes). The core compresses each 64-byte block by 16 word loads,
// 64 rounds of one shared round unit and one chaining add. The sustained
// rate is set by the one-byte-per-cycle front: the four-word queue holds
// only 16 bytes across the round and add steps, and the rest of the block
// arrives while the core loads.
// The closing word is followed by padding and one or two block compressions
// before o_out.valid rises.
// A stalled receiver holds the digest in the output register; the core keeps
// hashing the next message and waits only before a second digest.
// Reset (i_rst_n low, synchronous) empties the queue, drops any partial
// message and loads the initial chaining words.
module sha256_message_hasher_top #(
    parameter int P_FIFO_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha256_in_if.sink     i_in,
    sha256_out_if.source  o_out
);

    logic               w_q_push;
    logic               w_q_full;
    logic               w_q_pop;
    logic               w_q_empty;
    sha256_pkg::t_qword w_q_wr;
    sha256_pkg::t_qword w_q_rd;

    sha256_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_data (w_q_wr)
    );

    sha256_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wr),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rd),
        .o_empty (w_q_empty)
    );

    sha256_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .o_q_pop   (w_q_pop),
        .i_q_data  (w_q_rd),
        .o_out     (o_out)
    );

endmodule

// ===== dv/sha256_message_hasher_top_test.sv =====
`timescale 1ns / 1ps

module sha256_message_hasher_top_test;

    localparam int RESET_CYCLES   = 5;
    localparam int ITEM_TARGET    = 1600;
    localparam int SETTLE_CYCLES  = 300;
    localparam int N_BOUNDARY     = 14;
    // lengths around the padding and block limits
    localparam int BOUNDARY_LENS [N_BOUNDARY] = '{
        0, 1, 3, 54, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128
    };

    typedef logic [7:0][31:0] t_digest;

    class digest_scoreboard;
        sha256_pkg::t_word chain [8];
        logic [7:0]        blk [64];
        logic [63:0]       bit_count;
        int                fill;
        t_digest           pending_digests [$];
        int                errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            chain     = sha256_pkg::H_INIT;
            bit_count = '0;
            fill      = 0;
        endfunction

        function sha256_pkg::t_word rotr(sha256_pkg::t_word x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            sha256_pkg::t_word w [64];
            sha256_pkg::t_word v [8];
            sha256_pkg::t_word s0, s1, t1, t2;
            for (int i = 0; i < 16; i++) begin
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            end
            for (int i = 16; i < 64; i++) begin
                s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            v = chain;
            for (int i = 0; i < 64; i++) begin
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::K_ROUND[i] + w[i];
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) begin
                chain[i] = chain[i] + v[i];
            end
        endfunction

        function void absorb(logic [7:0] b);
            blk[fill] = b;
            fill++;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
        endfunction

        function void note_word(logic [7:0] data, logic bv, logic lst);
            logic [63:0] len;
            t_digest     d;
            if (bv) begin
                absorb(data);
                bit_count = bit_count + 64'd8;
            end
            if (!lst) return;
            len = bit_count;
            absorb(sha256_pkg::PAD_MARK);
            while (fill != int'(sha256_pkg::LEN_POS)) absorb(8'h00);
            for (int i = 0; i < 8; i++) begin
                absorb(len[63-8*i -: 8]);
            end
            for (int i = 0; i < 8; i++) begin
                d[i] = chain[i];
            end
            pending_digests.insert(pending_digests.size(), d);
            restart();
        endfunction

        function void check_digest(t_digest got);
            t_digest want;
            if (pending_digests.size() == 0) begin
                $display("%0t: expected no digest, got %h", $time, got);
                errors++;
                return;
            end
            want = pending_digests.pop_front();
            for (int i = 0; i < 8; i++) begin
                if (want[i] !== got[i]) begin
                    $display("%0t: hash_word_%0d expected %h got %h",
                             $time, i, want[i], got[i]);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return pending_digests.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    sha256_in_if  in_if ();
    sha256_out_if out_if ();

    sha256_message_hasher_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    digest_scoreboard sb = new();
    int in_calm  = 0;
    int out_calm = 0;

    always #5 i_clk = ~i_clk;

    // occasional stretches with no idle cycles at all
    function automatic int pick_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 60);
        return $urandom_range(0, 6);
    endfunction

    task automatic send_word(input logic [7:0] d, input logic bv, input logic lst);
        int gap;
        gap = pick_gap(in_calm);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= d;
        in_if.byte_valid <= bv;
        in_if.last       <= lst;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_word(d, bv, lst);
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        out_if.ready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        forever begin
            int gap;
            gap = pick_gap(out_calm);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            sb.check_digest({out_if.hash_word_7, out_if.hash_word_6, out_if.hash_word_5,
                             out_if.hash_word_4, out_if.hash_word_3, out_if.hash_word_2,
                             out_if.hash_word_1, out_if.hash_word_0});
        end
    end

    initial begin
        int  counted;
        int  len;
        bit  bare_end;
        in_if.valid      <= 1'b0;
        in_if.data_byte  <= 8'h00;
        in_if.byte_valid <= 1'b0;
        in_if.last       <= 1'b0;
        i_rst_n          <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty message
        send_word(8'h5a, 1'b0, 1'b1);
        // idle word, then single-byte messages at the byte extremes
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hff, 1'b1, 1'b1);
        // "abc"
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        // close without a byte after data, idle word in between
        send_word(8'haa, 1'b1, 1'b0);
        send_word(8'h55, 1'b1, 1'b0);
        send_word(8'h3c, 1'b0, 1'b0);
        send_word(8'hc3, 1'b0, 1'b1);
        send_word(8'h12, 1'b0, 1'b1);

        counted = 12;
        while (counted < ITEM_TARGET) begin
            if ($urandom_range(0, 4) < 2) len = BOUNDARY_LENS[$urandom_range(0, N_BOUNDARY - 1)];
            else len = $urandom_range(0, 140);
            bare_end = (len == 0) || ($urandom_range(0, 2) == 0);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_word(rand_byte(), 1'b0, 1'b0);
                    counted++;
                end
                send_word(rand_byte(), 1'b1, !bare_end && (k == len - 1));
                counted++;
            end
            if (bare_end) begin
                send_word(rand_byte(), 1'b0, 1'b1);
                counted++;
            end
        end
        in_if.valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
